// ===== design/spli_pkg.sv =====
package spli_pkg;

    localparam int DEPTH      = 256;
    localparam int COORD_BITS = 32;
    localparam int IN_W       = 32;
    localparam int NODE_W     = 9;
    localparam int NUM_W      = $clog2(DEPTH + 1);

    localparam logic [2:0] MODE_SEARCH  = 3'd0;
    localparam logic [2:0] MODE_CARRY   = 3'd1;
    localparam logic [2:0] MODE_FOUND   = 3'd2;
    localparam logic [2:0] MODE_CREATED = 3'd3;
    localparam logic [2:0] MODE_FULL    = 3'd4;

    typedef struct packed {
        logic                  active;
        logic [2:0]            mode;
        logic                  no_room;
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [NUM_W-1:0]      num;
    } token_t;

    function automatic logic [COORD_BITS-1:0] coord_key(input logic [IN_W-1:0] raw);
        logic signed [63:0] wide;
        wide = 64'(signed'(raw));
        return wide[COORD_BITS-1:0];
    endfunction

endpackage

// ===== design/spli_cell.sv =====
module spli_cell (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             advance,
    input  spli_pkg::token_t tok_in,
    output spli_pkg::token_t tok_out
);
    import spli_pkg::*;

    logic                  valid_reg, valid_next;
    logic [COORD_BITS-1:0] x_reg, x_next;
    logic [COORD_BITS-1:0] y_reg, y_next;
    logic [NUM_W-1:0]      num_reg, num_next;
    token_t                tok_reg, tok_next;

    logic ent_eq;
    logic ent_lt;

    assign ent_eq = valid_reg && (x_reg == tok_in.x) && (y_reg == tok_in.y);
    assign ent_lt = valid_reg && (($signed(x_reg) < $signed(tok_in.x)) ||
                    ((x_reg == tok_in.x) && ($signed(y_reg) < $signed(tok_in.y))));

    always_comb begin
        valid_next = valid_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        num_next   = num_reg;
        tok_next   = tok_in;
        if (tok_in.active) begin
            case (tok_in.mode)
                MODE_SEARCH: begin
                    if (ent_eq) begin
                        tok_next.mode = MODE_FOUND;
                        tok_next.num  = num_reg;
                    end else if (ent_lt) begin
                        tok_next = tok_in;
                    end else if (tok_in.no_room) begin
                        tok_next.mode = MODE_FULL;
                    end else begin
                        valid_next = 1'b1;
                        x_next     = tok_in.x;
                        y_next     = tok_in.y;
                        num_next   = tok_in.num;
                        tok_next.x   = x_reg;
                        tok_next.y   = y_reg;
                        tok_next.num = num_reg;
                        tok_next.mode = valid_reg ? MODE_CARRY : MODE_CREATED;
                    end
                end
                MODE_CARRY: begin
                    valid_next   = 1'b1;
                    x_next       = tok_in.x;
                    y_next       = tok_in.y;
                    num_next     = tok_in.num;
                    tok_next.x   = x_reg;
                    tok_next.y   = y_reg;
                    tok_next.num = num_reg;
                    tok_next.mode = valid_reg ? MODE_CARRY : MODE_CREATED;
                end
                default: begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= 1'b0;
            tok_reg.active <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            num_reg <= num_next;
        end
    end

    assign tok_out = tok_reg;

endmodule

// ===== design/sorted_point_lookup_insert_core.sv =====
// Sorted point table with insert-on-miss, built as a chain of DEPTH cells that
// each hold one entry (valid, x, y, number), kept sorted by signed x, then y.
// A point enters the first cell as a token and moves one cell per cycle
// while the chain advances; on its way it matches an entry, takes its sorted
// slot and pushes the tail of the table one cell down, or finds no room. Every
// transaction returns one result, registered at the output once the token
// leaves the last cell; one point is in flight at a time, so a new point is
// taken only once the previous result is loaded into the output register.
// A stalled result holds the chain. The table is empty after reset.
module sorted_point_lookup_insert_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [spli_pkg::IN_W-1:0]   s_point_x,
    input  logic [spli_pkg::IN_W-1:0]   s_point_y,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [spli_pkg::NODE_W-1:0] m_node_number,
    output logic                        m_created,
    output logic                        m_table_full
);
    import spli_pkg::*;

    token_t chain [DEPTH];
    token_t head;
    token_t tail;

    logic             advance;
    logic             exit_fire;
    logic             busy_reg, busy_next;
    logic [NUM_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    logic [NODE_W-1:0] num_out_reg, num_out_next;
    logic             created_reg, created_next;
    logic             full_reg, full_next;

    assign tail      = chain[DEPTH-1];
    assign advance   = !(tail.active && m_valid_reg && !m_ready);
    assign exit_fire = tail.active && advance;
    assign s_ready   = !busy_reg;

    always_comb begin
        head.active  = s_valid && !busy_reg;
        head.mode    = MODE_SEARCH;
        head.no_room = (count_reg == NUM_W'(DEPTH));
        head.x       = coord_key(s_point_x);
        head.y       = coord_key(s_point_y);
        head.num     = NUM_W'(count_reg + 1'b1);
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_first
                spli_cell u_cell (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .advance (advance),
                    .tok_in  (head),
                    .tok_out (chain[g])
                );
            end else begin : g_rest
                spli_cell u_cell (
                    .aclk    (aclk),
                    .aresetn (aresetn),
                    .advance (advance),
                    .tok_in  (chain[g-1]),
                    .tok_out (chain[g])
                );
            end
        end
    endgenerate

    always_comb begin
        busy_next    = busy_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        num_out_next = num_out_reg;
        created_next = created_reg;
        full_next    = full_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_valid && !busy_reg) begin
            busy_next = 1'b1;
        end
        if (exit_fire) begin
            busy_next    = 1'b0;
            m_valid_next = 1'b1;
            case (tail.mode)
                MODE_FOUND: begin
                    num_out_next = NODE_W'(tail.num);
                    created_next = 1'b0;
                    full_next    = 1'b0;
                end
                MODE_SEARCH, MODE_FULL: begin
                    num_out_next = '0;
                    created_next = 1'b0;
                    full_next    = 1'b1;
                end
                default: begin
                    num_out_next = NODE_W'(count_reg + 1'b1);
                    created_next = 1'b1;
                    full_next    = 1'b0;
                    count_next   = NUM_W'(count_reg + 1'b1);
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_out_reg <= num_out_next;
        created_reg <= created_next;
        full_reg    <= full_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_node_number = num_out_reg;
    assign m_created     = created_reg;
    assign m_table_full  = full_reg;

endmodule

// ===== verif/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import spli_pkg::*;

    localparam int N_DIRECTED  = 21;
    localparam int N_RANDOM    = 1580;
    localparam int CYCLE_LIMIT = 2_500_000;

    localparam logic [IN_W-1:0] CORNER_VALUES [5] = '{
        32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001
    };

    typedef struct packed {
        logic [NODE_W-1:0] node_number;
        logic              created;
        logic              table_full;
    } numbering_t;

    typedef struct packed {
        logic [IN_W-1:0] x;
        logic [IN_W-1:0] y;
        logic            known;
        numbering_t      res;
    } point_row_t;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [IN_W-1:0]   s_point_x;
    logic [IN_W-1:0]   s_point_y;
    logic              m_valid;
    logic              m_ready;
    logic [NODE_W-1:0] m_node_number;
    logic              m_created;
    logic              m_table_full;

    // point table as the block should hold it: sorted by signed x, then y
    logic signed [COORD_BITS-1:0] table_x   [DEPTH];
    logic signed [COORD_BITS-1:0] table_y   [DEPTH];
    logic [NODE_W-1:0]            table_num [DEPTH];
    int                           points_held = 0;

    numbering_t      pending_numbers [$];
    logic [IN_W-1:0] sent_x [$];
    logic [IN_W-1:0] sent_y [$];

    int mismatch_count = 0;
    int cycle_count    = 0;
    int ready_hold     = 0;
    bit calm           = 1'b0;

    sorted_point_lookup_insert_core DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_point_x     (s_point_x),
        .s_point_y     (s_point_y),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_node_number (m_node_number),
        .m_created     (m_created),
        .m_table_full  (m_table_full)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    function automatic numbering_t number_point(input logic [IN_W-1:0] px,
                                                input logic [IN_W-1:0] py);
        logic signed [COORD_BITS-1:0] kx;
        logic signed [COORD_BITS-1:0] ky;
        int slot;
        kx   = COORD_BITS'(signed'(px));
        ky   = COORD_BITS'(signed'(py));
        slot = points_held;
        for (int i = 0; i < points_held; i++) begin
            if (table_x[i] == kx && table_y[i] == ky)
                return '{table_num[i], 1'b0, 1'b0};
            if (table_x[i] > kx || (table_x[i] == kx && table_y[i] > ky)) begin
                slot = i;
                break;
            end
        end
        if (points_held >= DEPTH)
            return '{'0, 1'b0, 1'b1};
        for (int i = points_held; i > slot; i--) begin
            table_x[i]   = table_x[i-1];
            table_y[i]   = table_y[i-1];
            table_num[i] = table_num[i-1];
        end
        table_x[slot]   = kx;
        table_y[slot]   = ky;
        table_num[slot] = NODE_W'(points_held + 1);
        points_held++;
        return '{NODE_W'(points_held), 1'b1, 1'b0};
    endfunction

    function automatic logic [IN_W-1:0] pick_coord();
        int k;
        case ($urandom_range(0, 9))
            0: return CORNER_VALUES[$urandom_range(0, 4)];
            1, 2: return IN_W'(int'($urandom_range(0, 16)) - 8);
            3: begin
                k = $urandom_range(0, sent_x.size() - 1);
                return $urandom_range(0, 1) ? sent_x[k] : sent_y[k];
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic send_point(input logic [IN_W-1:0] px, input logic [IN_W-1:0] py,
                              input logic known, input numbering_t typed);
        numbering_t predicted;
        int bursts;
        bursts = 0;
        if (!calm) begin
            case ($urandom_range(0, 7))
                0, 1, 2: bursts = 1;
                default: bursts = 0;
            endcase
        end
        repeat (bursts) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_point_x = px;
        s_point_y = py;
        s_valid   = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = number_point(px, py);
        pending_numbers.push_back(known ? typed : predicted);
        sent_x.push_back(px);
        sent_y.push_back(py);
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        if (ready_hold > 0) begin
            ready_hold--;
            m_ready = 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            ready_hold = $urandom_range(1, 3) - 1;
            m_ready    = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    always @(posedge aclk) begin
        numbering_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_numbers.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction: node %0d created %0b full %0b",
                                          m_node_number, m_created, m_table_full));
            end else begin
                want = pending_numbers.pop_front();
                if (m_node_number !== want.node_number)
                    report_mismatch($sformatf("node_number %0d, expected %0d",
                                              m_node_number, want.node_number));
                if (m_created !== want.created)
                    report_mismatch($sformatf("created %0b, expected %0b",
                                              m_created, want.created));
                if (m_table_full !== want.table_full)
                    report_mismatch($sformatf("table_full %0b, expected %0b",
                                              m_table_full, want.table_full));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        point_row_t      directed_rows [N_DIRECTED];
        logic [IN_W-1:0] px;
        logic [IN_W-1:0] py;
        int              k;

        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_point_x = '0;
        s_point_y = '0;
        m_ready   = 1'b0;

        // typed rows: numbers run in insertion order from an empty table
        directed_rows = '{
            '{32'h0000_0000, 32'h0000_0000, 1'b1, '{9'd1,  1'b1, 1'b0}},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{9'd2,  1'b1, 1'b0}},
            '{32'h8000_0000, 32'h8000_0000, 1'b1, '{9'd3,  1'b1, 1'b0}},
            '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{9'd4,  1'b1, 1'b0}},
            '{32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '{9'd5,  1'b1, 1'b0}},
            '{32'h0000_0000, 32'h0000_0000, 1'b1, '{9'd1,  1'b0, 1'b0}},
            '{32'h8000_0000, 32'h8000_0000, 1'b1, '{9'd3,  1'b0, 1'b0}},
            '{32'h0000_0000, 32'h0000_0001, 1'b1, '{9'd6,  1'b1, 1'b0}},
            '{32'h0000_0001, 32'h0000_0000, 1'b1, '{9'd7,  1'b1, 1'b0}},
            '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{9'd8,  1'b1, 1'b0}},
            '{32'h0000_0000, 32'hFFFF_FFFF, 1'b1, '{9'd9,  1'b1, 1'b0}},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, '{9'd2,  1'b0, 1'b0}},
            '{32'hFFFF_FFFF, 32'h0000_0000, 1'b1, '{9'd8,  1'b0, 1'b0}},
            '{32'h0001_0000, 32'hFFFF_0000, 1'b1, '{9'd10, 1'b1, 1'b0}},
            '{32'hAAAA_AAAA, 32'h5555_5555, 1'b1, '{9'd11, 1'b1, 1'b0}},
            '{32'h5555_5555, 32'hAAAA_AAAA, 1'b1, '{9'd12, 1'b1, 1'b0}},
            '{32'h0000_0000, 32'h0000_0001, 1'b1, '{9'd6,  1'b0, 1'b0}},
            '{32'h4000_0000, 32'hC000_0000, 1'b0, '0},
            '{32'hC000_0000, 32'h4000_0000, 1'b0, '0},
            '{32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '{9'd4,  1'b0, 1'b0}},
            '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0}
        };

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (directed_rows[i])
            send_point(directed_rows[i].x, directed_rows[i].y,
                       directed_rows[i].known, directed_rows[i].res);

        // fills the table, then keeps mixing hits and misses against a full one
        for (int n = 0; n < N_RANDOM; n++) begin
            calm = (n >= 700 && n < 900) || n >= N_RANDOM - 250;
            if ($urandom_range(0, 99) < 45) begin
                k  = $urandom_range(0, sent_x.size() - 1);
                px = sent_x[k];
                py = sent_y[k];
            end else begin
                px = pick_coord();
                py = pick_coord();
            end
            send_point(px, py, 1'b0, '0);
        end
        s_valid = 1'b0;

        while (pending_numbers.size() != 0) @(posedge aclk);
        repeat (DEPTH + 16) @(posedge aclk);

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
